[sv/url_path_decode_sanitize_macros.svh]
// ----------------------------------------------------------------------------
// url_path_decode_sanitize_macros
// Concurrent assertion macros shared by the path decoder RTL.
// ----------------------------------------------------------------------------
`ifndef URL_PATH_DECODE_SANITIZE_MACROS_SVH
`define URL_PATH_DECODE_SANITIZE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define UPDS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UPDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UPDS_ASSERT_IMPL(label, ante, cons, msg)
`define UPDS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/upds_pkg.sv]
// ----------------------------------------------------------------------------
// upds_pkg
// Types and constants of the request path decoder and sanitizer.
// ----------------------------------------------------------------------------
package upds_pkg;

  localparam int MAX_PATH = 4096;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 12;
  localparam int STATUS_W = 2;

  // length limit after reset, capped at the register range
  localparam logic [LEN_W-1:0] MAX_LEN_RESET =
    LEN_W'(((MAX_PATH - 1) > ((1 << LEN_W) - 1)) ? ((1 << LEN_W) - 1) : (MAX_PATH - 1));

  // character codes
  localparam logic [BYTE_W-1:0] CH_PERCENT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FORBIDDEN = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DOTS_START = 2'd0,
    DOTS_ONE   = 2'd1,
    DOTS_TWO   = 2'd2,
    DOTS_OTHER = 2'd3
  } dots_t;

  // per-path stream state
  typedef struct packed {
    phase_t           phase;
    logic [3:0]       high_nibble;
    logic [LEN_W-1:0] count;
    dots_t            dots;
    status_t          sticky;
    logic             dotdot_seen;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:       PH_NORMAL,
    high_nibble: 4'd0,
    count:       '0,
    dots:        DOTS_START,
    sticky:      ST_OK,
    dotdot_seen: 1'b0
  };

  // one step's result
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              done_res;
    status_t           status;
  } res_t;

endpackage

[sv/upds_if.sv]
// ----------------------------------------------------------------------------
// upds_if
// Valid/ready channels of the path decoder: input bytes, results, config.
// ----------------------------------------------------------------------------
interface upds_in_if;
  import upds_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface upds_out_if;
  import upds_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                byte_valid;
  logic                done_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_byte, byte_valid, done_res, status, input ready);
  modport sink   (input valid, out_byte, byte_valid, done_res, status, output ready);
endinterface

interface upds_cfg_if;
  import upds_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_decoded_length;

  modport source (output valid, max_decoded_length, input ready);
  modport sink   (input valid, max_decoded_length, output ready);
endinterface

[sv/upds_step.sv]
// ----------------------------------------------------------------------------
// upds_step
// One-byte decode step: escape decoding, byte checks, length limit and
// dot-dot segment tracking, giving the next stream state and the result.
// ----------------------------------------------------------------------------
module upds_step (
  input  upds_pkg::state_t                 state_i,
  input  logic [upds_pkg::BYTE_W-1:0]      byte_i,
  input  logic                             last_i,
  input  logic [upds_pkg::LEN_W-1:0]       max_len_i,
  output upds_pkg::state_t                 state_o,
  output upds_pkg::res_t                   res_o
);
  import upds_pkg::*;

  logic              nib_ok;
  logic [3:0]        nib_val;
  logic              have;
  logic [BYTE_W-1:0] dec;
  state_t            st;
  status_t           final_status;

  // hex digit of either case
  always_comb begin
    nib_ok  = 1'b1;
    nib_val = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      nib_val = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      nib_val = byte_i[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  // decode, checks and state update
  always_comb begin
    st   = state_i;
    have = 1'b0;
    dec  = CH_NUL;
    if (state_i.sticky == ST_OK) begin
      // escape handling
      if (state_i.phase == PH_NORMAL) begin
        if (byte_i == CH_PERCENT) begin
          st.phase = PH_HIGH;
        end else begin
          dec  = (byte_i == CH_PLUS) ? CH_SPACE : byte_i;
          have = 1'b1;
        end
      end else if (!nib_ok) begin
        st.sticky = ST_FORBIDDEN;
      end else if (state_i.phase == PH_HIGH) begin
        st.high_nibble = nib_val;
        st.phase       = PH_LOW;
      end else begin
        dec      = {state_i.high_nibble, nib_val};
        st.phase = PH_NORMAL;
        have     = 1'b1;
      end

      // decoded byte checks, limit and segment tracking
      if (have) begin
        if (dec == CH_NUL || dec == CH_BACKSLASH) begin
          st.sticky = ST_FORBIDDEN;
          have      = 1'b0;
        end else if (state_i.count >= max_len_i) begin
          st.sticky = ST_TOO_LONG;
          have      = 1'b0;
        end else begin
          st.count = state_i.count + LEN_W'(1);
          if (dec == CH_SLASH) begin
            if (state_i.dots == DOTS_TWO) begin
              st.dotdot_seen = 1'b1;
            end
            st.dots = DOTS_START;
          end else if (dec == CH_DOT) begin
            unique case (state_i.dots)
              DOTS_START: st.dots = DOTS_ONE;
              DOTS_ONE:   st.dots = DOTS_TWO;
              default:    st.dots = DOTS_OTHER;
            endcase
          end else begin
            st.dots = DOTS_OTHER;
          end
        end
      end
    end

    // end of path status
    final_status = st.sticky;
    if (last_i && st.sticky == ST_OK) begin
      if (st.phase != PH_NORMAL) begin
        final_status = ST_FORBIDDEN;
        have         = 1'b0;
      end else if (st.dotdot_seen || st.dots == DOTS_TWO) begin
        final_status = ST_FORBIDDEN;
      end
    end

    state_o = last_i ? STATE_CLEAR : st;

    res_o.emit       = have || last_i;
    res_o.out_byte   = have ? dec : CH_NUL;
    res_o.byte_valid = have;
    res_o.done_res   = last_i;
    res_o.status     = last_i ? final_status : ST_OK;
  end

endmodule

[sv/url_path_decode_sanitize.sv]
// ----------------------------------------------------------------------------
// url_path_decode_sanitize
// Streaming percent decoder and checker for a request path: one encoded byte
// per request in, at most one result per request out: decoded byte, status or both.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                    notes
//  in_s      in   in_byte[7:0], in_last                      one path byte
//  out_s     out  out_byte[7:0], byte_valid, done_res,       decoded byte or
//                 status[1:0]                                final status or both
//  cfg_s     in   max_decoded_length[11:0]                   always ready
//
//  One byte per cycle unless the result register stalls; an accepted byte
//  goes via the input register and decode step into the result register.
//  Stream state updates in the decode step, so each byte sees the last one.
//  A stalled result register holds the pipe; in_s.ready falls only then.
//  Reset clears the stream state and sets the length limit to 4095.
// ----------------------------------------------------------------------------
module url_path_decode_sanitize (
  input  logic        clk,
  input  logic        rst_n,
  upds_in_if.sink     in_s,
  upds_out_if.source  out_s,
  upds_cfg_if.sink    cfg_s
);
  import upds_pkg::*;
  `include "url_path_decode_sanitize_macros.svh"

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  state_t            state_r;
  state_t            state_nxt;
  res_t              step_res;
  logic [LEN_W-1:0]  max_len_r;
  logic              out_valid_r;
  res_t              out_res_r;
  logic              out_free;
  logic              s1_advance;

  // length limit register
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_s.valid) begin
      max_len_r <= cfg_s.max_decoded_length;
    end
  end

  // pipeline flow control
  assign out_free   = !out_valid_r || out_s.ready;
  assign s1_advance = s1_valid_r && (!step_res.emit || out_free);
  assign in_s.ready = !s1_valid_r || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      s1_byte_r <= in_s.in_byte;
      s1_last_r <= in_s.in_last;
    end
  end

  // decode step
  upds_step u_step (
    .state_i   (state_r),
    .byte_i    (s1_byte_r),
    .last_i    (s1_last_r),
    .max_len_i (max_len_r),
    .state_o   (state_nxt),
    .res_o     (step_res)
  );

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_advance && step_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_advance && step_res.emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.out_byte   = out_res_r.out_byte;
  assign out_s.byte_valid = out_res_r.byte_valid;
  assign out_s.done_res   = out_res_r.done_res;
  assign out_s.status     = out_res_r.status;

  // checks
  `UPDS_ASSERT_IMPL(a_no_bytes_after_error, s1_valid_r && state_r.sticky != ST_OK, !step_res.byte_valid, "decoded byte after error")
  `UPDS_ASSERT_NEXT(a_clear_after_last, s1_advance && s1_last_r, state_r.phase == PH_NORMAL && state_r.count == '0 && state_r.sticky == ST_OK, "stream state not cleared after last byte")
  `UPDS_ASSERT_IMPL(a_no_bad_byte_out, out_valid_r && out_res_r.byte_valid, out_res_r.out_byte != CH_NUL && out_res_r.out_byte != CH_BACKSLASH, "forbidden byte delivered")

endmodule

[tb/tb_url_path_decode_sanitize.sv]
// ----------------------------------------------------------------------------
// tb_url_path_decode_sanitize
// Self-checking bench for the request path decoder. Encoded paths (directed
// corner cases, then random well-formed and damaged paths) go in one byte per
// request under several length limits, with random idling on both channels.
// Every decoded byte and final status is checked against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_url_path_decode_sanitize;
  timeunit 1ns;
  timeprecision 1ps;

  import upds_pkg::*;

  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } path_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              bv;
    logic              done;
    status_t           st;
  } decoded_res_t;

  logic clk = 1'b0;
  logic rst_n;

  upds_in_if  in_ch ();
  upds_out_if out_ch ();
  upds_cfg_if cfg_ch ();

  url_path_decode_sanitize u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  // encoded bytes waiting to go in, decoded results waiting to come out
  path_byte_t   raw_path_q[$];
  decoded_res_t decoded_fifo[$];

  // bench copy of the decoder state
  logic [LEN_W-1:0] len_limit = MAX_LEN_RESET;
  phase_t           esc_phase;
  logic [3:0]       high_nib;
  logic [LEN_W-1:0] dec_count;
  dots_t            seg_dots;
  status_t          sticky;
  bit               dotdot_seen;

  bit in_fire, out_fire, cfg_fire;
  bit hold_req;
  int hold_left, src_gap, sink_gap;
  int src_idle_pct  = 10;
  int sink_idle_pct = 10;
  int queued_bytes, bad_results, quiet_cycles;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_path_state();
    esc_phase   = PH_NORMAL;
    high_nib    = 4'd0;
    dec_count   = '0;
    seg_dots    = DOTS_START;
    sticky      = ST_OK;
    dotdot_seen = 1'b0;
  endtask

  // decode one accepted byte, queue the result it causes
  task automatic decode_byte(input logic [BYTE_W-1:0] c, input logic last);
    bit                have, nib_ok;
    logic [BYTE_W-1:0] dec;
    logic [3:0]        nib;
    status_t           fin;
    have = 1'b0;
    dec  = CH_NUL;
    if (sticky == ST_OK) begin
      if (esc_phase == PH_NORMAL) begin
        if (c == CH_PERCENT) begin
          esc_phase = PH_HIGH;
        end else begin
          dec  = (c == CH_PLUS) ? CH_SPACE : c;
          have = 1'b1;
        end
      end else begin
        // hex digit of either case
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
          nib = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
          nib = c[3:0] + 4'd9;
        end else begin
          nib_ok = 1'b0;
        end
        if (!nib_ok) begin
          sticky = ST_FORBIDDEN;
        end else if (esc_phase == PH_HIGH) begin
          high_nib  = nib;
          esc_phase = PH_LOW;
        end else begin
          dec       = {high_nib, nib};
          esc_phase = PH_NORMAL;
          have      = 1'b1;
        end
      end

      // forbidden bytes first, then length, then segment tracking
      if (have) begin
        if (dec == CH_NUL || dec == CH_BACKSLASH) begin
          sticky = ST_FORBIDDEN;
          have   = 1'b0;
        end else if (dec_count >= len_limit) begin
          sticky = ST_TOO_LONG;
          have   = 1'b0;
        end else begin
          dec_count = dec_count + 1'b1;
          if (dec == CH_SLASH) begin
            if (seg_dots == DOTS_TWO) dotdot_seen = 1'b1;
            seg_dots = DOTS_START;
          end else if (dec == CH_DOT) begin
            seg_dots = (seg_dots == DOTS_OTHER) ? DOTS_OTHER : dots_t'(seg_dots + 1);
          end else begin
            seg_dots = DOTS_OTHER;
          end
        end
      end
    end

    if (!last) begin
      if (have) decoded_fifo.push_back('{dec, 1'b1, 1'b0, ST_OK});
    end else begin
      // final status: cut-off escape, then dot-dot segment
      fin = sticky;
      if (fin == ST_OK) begin
        if (esc_phase != PH_NORMAL) begin
          fin  = ST_FORBIDDEN;
          have = 1'b0;
        end else if (dotdot_seen || seg_dots == DOTS_TWO) begin
          fin = ST_FORBIDDEN;
        end
      end
      decoded_fifo.push_back('{have ? dec : CH_NUL, have, 1'b1, fin});
      clear_path_state();
    end
  endtask

  task automatic log_mismatch(input string msg);
    if (bad_results < 10) $display("%0t: %s", $time, msg);
    bad_results++;
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input bit ends);
    raw_path_q.push_back('{b, ends});
    queued_bytes++;
  endtask

  task automatic queue_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], ends && i == s.len() - 1);
  endtask

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // one random path: mostly well formed, some damaged or pure noise
  task automatic queue_path(input int max_tokens);
    logic [BYTE_W-1:0] enc[$];
    logic [BYTE_W-1:0] v;
    int                kind, pick, pos;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(1, max_tokens)) begin
      pick = $urandom_range(0, 15);
      if (kind == 6) begin
        enc.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 3) begin
        enc.push_back(CH_DOT);
      end else if (pick < 5) begin
        enc.push_back(CH_SLASH);
      end else if (pick == 5) begin
        enc.push_back(CH_PLUS);
      end else if (pick < 10) begin
        // escaped byte, now and then an escaped dot or slash
        if (pick == 9) v = $urandom_range(0, 1) ? CH_DOT : CH_SLASH;
        else v = 8'($urandom_range(1, 255));
        if (v == CH_BACKSLASH) v = CH_PLUS;
        enc.push_back(CH_PERCENT);
        enc.push_back(hex_char(v[7:4], $urandom_range(0, 1)));
        enc.push_back(hex_char(v[3:0], $urandom_range(0, 1)));
      end else begin
        v = 8'($urandom_range(8'h21, 8'h7e));
        if (v == CH_PERCENT || v == CH_BACKSLASH) v = 8'h7e;
        enc.push_back(v);
      end
    end

    pos = $urandom_range(0, enc.size() - 1);
    case (kind)
      5: begin
        // a bare dot-dot segment
        enc.insert(pos, CH_SLASH);
        enc.insert(pos, CH_DOT);
        enc.insert(pos, CH_DOT);
        enc.insert(pos, CH_SLASH);
      end
      7: begin
        // non-hex byte where a digit is due, near the digit ranges
        case ($urandom_range(0, 5))
          0:       v = 8'h47;
          1:       v = 8'h67;
          2:       v = 8'h3a;
          3:       v = 8'h40;
          4:       v = 8'h60;
          default: v = 8'($urandom_range(0, 8'h2f));
        endcase
        enc.insert(pos, v);
        if ($urandom_range(0, 1)) enc.insert(pos, hex_char(4'($urandom_range(0, 15)), 1'b1));
        enc.insert(pos, CH_PERCENT);
      end
      8: begin
        // escape cut off by the end of the path
        enc.push_back(CH_PERCENT);
        if ($urandom_range(0, 1)) enc.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
      end
      9: begin
        // zero or backslash, raw or escaped
        case ($urandom_range(0, 3))
          0: enc.insert(pos, CH_NUL);
          1: enc.insert(pos, CH_BACKSLASH);
          2: begin
            enc.insert(pos, hex_char(4'h0, 1'b0));
            enc.insert(pos, hex_char(4'h0, 1'b0));
            enc.insert(pos, CH_PERCENT);
          end
          default: begin
            enc.insert(pos, hex_char(4'hc, $urandom_range(0, 1)));
            enc.insert(pos, hex_char(4'h5, 1'b0));
            enc.insert(pos, CH_PERCENT);
          end
        endcase
      end
      default: ;
    endcase

    foreach (enc[i]) queue_byte(enc[i], i == enc.size() - 1);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] lim);
    @(negedge clk);
    cfg_ch.valid              <= 1'b1;
    cfg_ch.max_decoded_length <= lim;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    len_limit = lim;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (raw_path_q.size() != 0 || decoded_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] lim, input int budget,
                           input bit pressure, input bit calm);
    int start;
    write_limit(lim);
    src_idle_pct  = calm ? 0 : $urandom_range(0, 3) * 6;
    sink_idle_pct = calm ? 0 : $urandom_range(0, 3) * 6;
    hold_req      = pressure;
    start         = queued_bytes;
    while (queued_bytes - start < budget) queue_path(12);
    wait_idle();
  endtask

  // request driver: holds an offered byte until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (raw_path_q.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(1, 8) - 1;
        in_ch.valid <= 1'b0;
      end else if (raw_path_q.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= raw_path_q[0].b;
        in_ch.in_last <= raw_path_q[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready: long hold on request, else random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      sink_gap = $urandom_range(1, 8) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: decode taken bytes, check results, watchdog
  always @(posedge clk) begin
    path_byte_t   pb;
    decoded_res_t want;
    in_fire  = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    cfg_fire = rst_n && cfg_ch.valid && cfg_ch.ready;

    if (in_fire) begin
      pb = raw_path_q.pop_front();
      decode_byte(pb.b, pb.last);
    end

    if (out_fire) begin
      if (decoded_fifo.size() == 0) begin
        log_mismatch($sformatf("unexpected result: byte %02h valid %0d done %0d status %0d",
                               out_ch.out_byte, out_ch.byte_valid, out_ch.done_res,
                               out_ch.status));
      end else begin
        want = decoded_fifo.pop_front();
        if (out_ch.out_byte !== want.b || out_ch.byte_valid !== want.bv ||
            out_ch.done_res !== want.done || out_ch.status !== want.st) begin
          log_mismatch($sformatf(
            "mismatch: expected byte %02h valid %0d done %0d status %0d, got %02h %0d %0d %0d",
            want.b, want.bv, want.done, want.st,
            out_ch.out_byte, out_ch.byte_valid, out_ch.done_res, out_ch.status));
        end
      end
    end

    if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.in_byte             = '0;
    in_ch.in_last             = 1'b0;
    out_ch.ready              = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.max_decoded_length = '0;
    clear_path_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: lowercase escapes, plus, top byte, bad and cut-off
    // escapes, zero and backslash raw and escaped, dot-dot segments
    write_limit(12'd4095);
    queue_text("%4a+", 1'b0);
    queue_byte(8'hff, 1'b1);
    queue_text("%G1", 1'b1);
    queue_text("%4", 1'b1);
    queue_text("%00", 1'b1);
    queue_byte(CH_NUL, 1'b1);
    queue_text("%5c", 1'b1);
    queue_byte(CH_BACKSLASH, 1'b1);
    queue_text("../a", 1'b1);
    queue_text("%2e.", 1'b1);
    wait_idle();

    // random phases over several length limits
    run_phase(12'd1, 150, 1'b0, 1'b0);
    run_phase(12'd4095, 250, 1'b1, 1'b0);
    run_phase(12'($urandom_range(2, 16)), 250, 1'b0, 1'b0);
    run_phase(12'($urandom_range(1, 4095)), 200, 1'b0, 1'b0);
    run_phase(12'd3, 200, 1'b0, 1'b0);
    run_phase(12'd4095, 200, 1'b0, 1'b1);

    if (bad_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
